### rtl/core/cba_pkg.sv
`default_nettype none

package cba_pkg;

  // Model geometry and coder constants
  localparam int MAX_CONTEXT_BITS_DEF = 16;
  localparam int MIN_CONTEXT_BITS     = 8;
  localparam logic [4:0] CONTEXT_BITS_RESET = 5'd16;
  localparam logic [7:0] WEIGHT_INIT  = 8'd128;
  localparam logic [7:0] HASH_MUL     = 8'd251;
  localparam logic [31:0] RANGE_HIGH_RESET = 32'hFFFF_FFFF;

  // Command codes
  localparam logic [1:0] CMD_ENCODE = 2'd0;
  localparam logic [1:0] CMD_FLUSH  = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // One byte handed from the coder to the output stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } push_t;

endpackage

`default_nettype wire

### rtl/core/cba_model_mem.sv
`default_nettype none

module cba_model_mem #(
  parameter int ADDR_BITS = cba_pkg::MAX_CONTEXT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [7:0]           wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [7:0]           rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/cba_out_stage.sv
`default_nettype none

module cba_out_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cba_pkg::push_t push,
  output logic                can_push,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic                last
);

  // Room when empty or when the held item leaves this cycle
  assign can_push = !out_valid || !out_stall;

  // Hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid && can_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load payload only when there is room for it
  always_ff @(posedge clk) begin
    if (push.valid && can_push) begin
      out_byte <= push.data;
      last     <= push.last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/context_binary_arith_encoder.sv
`default_nettype none
// Context-modelled binary range encoder, 32-bit range, one byte per item.
// Input channel (in_valid/in_stall): command and data_byte. Encode codes
// data_byte MSB first as eight bits; flush drains the range (up to four
// bytes); reset clears range, history and every model weight to 128.
// Output channel (out_valid/out_stall): out_byte, with last set on the
// final byte of an item. Items that give no byte give no output.
// cfg_write/cfg_data set context_bits; the user must write it only while
// the block is idle, and the block itself does not enforce this. One item
// is taken at a time: each coded bit passes hash, model read, code and
// write back, and normalise, where any bytes are emitted; in_stall stays
// high until the item is done. The model memory read-modify-write and the
// serial dependence of each bit's range on the one before set the pace.
// A produced byte waits in a pending register until the next byte or the
// end of the item, then passes to the registered output stage.
// Reset, and the reset command, start a clearing pass that writes 128 to
// all 2^MAX_CONTEXT_BITS model entries, one per cycle; no item is accepted
// during it. When the receiver stalls the output stage holds its byte and
// the coder waits at its next byte.
module context_binary_arith_encoder #(
  parameter int MAX_CONTEXT_BITS = cba_pkg::MAX_CONTEXT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last,
  input  wire logic       cfg_write,
  input  wire logic [4:0] cfg_data
);

  localparam int AW = MAX_CONTEXT_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CODE  = 3'd4;
  localparam logic [2:0] S_NORM  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [4:0]    context_bits;
  logic [31:0]   rmin;
  logic [31:0]   rmax;
  logic [31:0]   hist;
  logic [7:0]    data_reg;
  logic [2:0]    bit_cnt;
  logic [AW-1:0] idx;
  logic [AW-1:0] clr_cnt;
  logic [23:0]   rdiff;
  logic          pend_valid;
  logic [7:0]    pend_byte;

  logic          in_take;
  logic [4:0]    cb_eff;
  logic [AW-1:0] mask;
  logic [23:0]   hprod;
  logic [31:0]   mixed;
  logic [AW-1:0] idx_next;
  logic [31:0]   rspan;
  logic [7:0]    mem_rd;
  logic [7:0]    w;
  logic [31:0]   prod;
  logic [31:0]   split;
  logic          cur_bit;
  logic [7:0]    w_new;
  logic [8:0]    inc9;
  logic [3:0]    inc;
  logic [2:0]    dec;
  logic          emit;
  logic          advance;
  logic          can_push;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  cba_pkg::push_t push;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Clamp the configured context width
  always_comb begin
    if (context_bits < 5'(cba_pkg::MIN_CONTEXT_BITS)) begin
      cb_eff = 5'(cba_pkg::MIN_CONTEXT_BITS);
    end else if (context_bits > 5'(AW)) begin
      cb_eff = 5'(AW);
    end else begin
      cb_eff = context_bits;
    end
  end

  // Index mask from the clamped width
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = (5'(i) < cb_eff);
    end
  end

  // Hash the history into a model index
  assign hprod    = 24'(hist[31:16]) * 24'(cba_pkg::HASH_MUL);
  assign mixed    = hist ^ {hprod[23:8], 16'h0000};
  assign idx_next = mixed[AW-1:0] & mask;
  assign rspan    = rmax - rmin;

  // Split point and weight update
  assign w       = mem_rd;
  assign cur_bit = data_reg[bit_cnt];
  assign prod    = 32'(rdiff) * 32'(w);
  assign split   = rmin + prod;

  always_comb begin
    inc9 = 9'd256 - {1'b0, w};
    inc  = inc9[8:5];
    dec  = w[7:5];
    if (cur_bit) begin
      w_new = w - {5'd0, dec};
      if (dec == 3'd0 && w != 8'd0) begin
        w_new = w - 8'd1;
      end
    end else begin
      w_new = w + {4'd0, inc};
      if (inc == 4'd0 && w != 8'hFF) begin
        w_new = w + 8'd1;
      end
    end
  end

  // Byte emission: a produced byte waits in the pending register until the
  // next one shows it was not the last of the item
  always_comb begin
    emit = 1'b0;
    unique case (state)
      S_NORM:  emit = (rmin[31:24] == rmax[31:24]);
      S_FLUSH: emit = (rmin != 32'h0) || (rmax != cba_pkg::RANGE_HIGH_RESET);
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    push.data  = pend_byte;
    push.last  = (state == S_DONE);
    push.valid = pend_valid && (emit || state == S_DONE);
  end

  assign advance = !push.valid || can_push;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          unique case (command)
            cba_pkg::CMD_ENCODE: state_next = S_HASH;
            cba_pkg::CMD_FLUSH:  state_next = S_FLUSH;
            cba_pkg::CMD_RESET:  state_next = S_CLEAR;
            cba_pkg::CMD_NONE:   state_next = S_IDLE;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (&clr_cnt) begin
          state_next = S_IDLE;
        end
      end
      S_HASH: state_next = S_READ;
      S_READ: state_next = S_CODE;
      S_CODE: state_next = S_NORM;
      S_NORM: begin
        if (!emit) begin
          state_next = (bit_cnt == 3'd0) ? S_DONE : S_HASH;
        end
      end
      S_FLUSH: begin
        if (!emit) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (advance) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      context_bits <= cba_pkg::CONTEXT_BITS_RESET;
      rmin         <= 32'h0;
      rmax         <= cba_pkg::RANGE_HIGH_RESET;
      hist         <= 32'h0;
      pend_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        context_bits <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          clr_cnt <= '0;
          if (in_take && command == cba_pkg::CMD_RESET) begin
            rmin <= 32'h0;
            rmax <= cba_pkg::RANGE_HIGH_RESET;
            hist <= 32'h0;
          end
        end
        S_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        S_CODE: begin
          if (cur_bit) begin
            rmin <= split + 32'd1;
          end else begin
            rmax <= split;
          end
          hist <= {hist[30:0], cur_bit};
        end
        S_NORM, S_FLUSH: begin
          if (emit && advance) begin
            pend_valid <= 1'b1;
            rmin       <= {rmin[23:0], 8'h00};
            rmax       <= {rmax[23:0], 8'hFF};
          end
        end
        S_DONE: begin
          if (advance) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      data_reg <= data_byte;
      bit_cnt  <= 3'd7;
    end
    if (state == S_HASH) begin
      idx   <= idx_next;
      rdiff <= rspan[31:8];
    end
    if (state == S_NORM && !emit && bit_cnt != 3'd0) begin
      bit_cnt <= bit_cnt - 3'd1;
    end
    if ((state == S_NORM || state == S_FLUSH) && emit && advance) begin
      pend_byte <= rmin[31:24];
    end
  end

  // Model memory: clearing pass or write-back of the coded bit's weight.
  // The write-back in the code state lands before the next bit's hash and
  // read states, so no forwarding.
  assign mem_we    = (state == S_CLEAR) || (state == S_CODE);
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : idx;
  assign mem_wdata = (state == S_CLEAR) ? cba_pkg::WEIGHT_INIT : w_new;

  cba_model_mem #(
    .ADDR_BITS (AW)
  ) u_model (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (idx),
    .rd_data (mem_rd)
  );

  cba_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

`ifndef NO_ASSERTIONS
  // Outside a flush the coded interval never inverts
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    state != S_FLUSH |-> rmin <= rmax) else $error("range_low above range_high");

  // Between items the range is normalised
  a_idle_norm: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> rmin[31:24] != rmax[31:24])
    else $error("idle with unnormalised range");

  // No byte of an earlier item is left pending when a new item starts
  a_no_stale: assert property (@(posedge clk) disable iff (rst)
    in_take |-> !pend_valid) else $error("pending byte at item start");
`endif

endmodule

`default_nettype wire
